@@ rtl/ipv4_length_padding_decider_macros.svh @@
// Assertion helpers shared by the RTL of the length padding decider.
`ifndef IPV4_LENGTH_PADDING_DECIDER_MACROS_SVH
`define IPV4_LENGTH_PADDING_DECIDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lpd_pkg.sv @@
package lpd_pkg;

    localparam int unsigned DIV_STAGES     = 8;
    localparam int unsigned BITS_PER_STAGE = 4;

    localparam logic [15:0] DEFAULT_MTU    = 16'd1460;
    localparam logic [10:0] PAD_MIN        = 11'd64;
    localparam logic [10:0] PAD_MAX        = 11'd1400;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    typedef enum logic [2:0] {
        ACT_UNTOUCHED = 3'd0,
        ACT_SKIPPED   = 3'd1,
        ACT_NOT_SEL   = 3'd2,
        ACT_PADDED    = 3'd3,
        ACT_ZERO_PAD  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        REG_ENABLE    = 3'd0,
        REG_FILL_PCT  = 3'd1,
        REG_MTU       = 3'd2,
        REG_MIN_LEN   = 3'd3,
        REG_PAD_MODE  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_FILL     = 2'd0,
        MODE_UNIFORM  = 2'd1,
        MODE_CENTRED  = 2'd2,
        MODE_UNUSED   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [15:0] frm_bytes;
        logic [15:0] ether_type;
        logic        headers_present;
        logic [15:0] ip_total_len;
        logic [15:0] ip_checksum;
        logic [31:0] rand_decide;
        logic [31:0] rand_size;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [10:0] pad_bytes;
        logic [15:0] new_ip_total_len;
        logic [15:0] new_ip_checksum;
    } t_out_item;

    // Work carried down the pipeline while the remainder is formed.
    typedef struct packed {
        t_action     act;
        logic        big;
        t_mode       mode;
        logic [15:0] d;
        logic [13:0] var_q;
        logic [15:0] divisor;
        logic [31:0] rnd;
        logic [15:0] rem;
        logic [15:0] tlen;
        logic [15:0] csum;
    } t_work;

    // One restoring step of the remainder: shift in one dividend bit.
    function automatic logic [15:0] rem_step(logic [15:0] rem, logic b, logic [15:0] div);
        logic [16:0] t;
        logic [16:0] s;
        t = {rem, b};
        s = t - {1'b0, div};
        if (t >= {1'b0, div}) begin
            return s[15:0];
        end else begin
            return t[15:0];
        end
    endfunction

endpackage

@@ rtl/ipv4_length_padding_decider.sv @@
// IPv4 length padding decider.
// Input channel: one frame descriptor per transaction (i_in_valid / o_in_ready,
// payload i_in_data). Output channel: one decision per transaction
// (o_out_valid / i_out_ready, payload o_out_data) with the action, the pad
// size, the new total length and the incrementally updated header checksum.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 enable, 1 fill percent, 2 target MTU, 3 minimum length, 4 pad mode);
// write only while no transaction is in flight.
// A result passes eleven register stages, the first loaded at the accepting
// edge: one for the eligibility checks, eight of a pipelined remainder unit
// that resolves four bits of the 32-bit random word each, one for the pad
// size and clamp, and one output register for length and checksum.
// Throughput is one transaction per cycle while the receiver does not stall.
// Each stage has its own valid bit and moves forward whenever the next stage
// is empty or moving, so a stalled receiver only holds the pipeline back
// once it is full; nothing is dropped.
// A synchronous active-low reset empties the pipeline and restores the
// registers to their reset values (target MTU 1460, the rest zero).
`include "ipv4_length_padding_decider_macros.svh"

module ipv4_length_padding_decider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lpd_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lpd_pkg::t_out_item o_out_data
);
    import lpd_pkg::*;

    logic        r_enable;
    logic [6:0]  r_fill_pct;
    logic [15:0] r_mtu;
    logic [15:0] r_min_len;
    logic [1:0]  r_pad_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_fill_pct <= '0;
            r_mtu      <= DEFAULT_MTU;
            r_min_len  <= '0;
            r_pad_mode <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ENABLE:   r_enable   <= i_cfg_data[0];
                REG_FILL_PCT: r_fill_pct <= i_cfg_data[6:0];
                REG_MTU:      r_mtu      <= i_cfg_data;
                REG_MIN_LEN:  r_min_len  <= i_cfg_data;
                REG_PAD_MODE: r_pad_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its contents move on.
    logic                  en_s1, en_s10, en_out;
    logic [DIV_STAGES-1:0] en_dv;
    logic                  r_v1, r_v10, r_vout;
    logic [DIV_STAGES-1:0] r_vdv;

    assign en_out = !r_vout || i_out_ready;
    assign en_s10 = !r_v10 || en_out;
    always_comb begin
        en_dv[DIV_STAGES-1] = !r_vdv[DIV_STAGES-1] || en_s10;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            en_dv[k] = !r_vdv[k] || en_dv[k+1];
        end
    end
    assign en_s1      = !r_v1 || en_dv[0];
    assign o_in_ready = en_s1;

    // Stage 1: eligibility, pad decision and divisor selection.
    t_work       n_s1, r_s1;
    logic [38:0] dec_lhs, dec_rhs;
    logic [15:0] mtu_eff;
    logic [13:0] var_q;
    logic [15:0] div_raw;

    always_comb begin
        // Not selected exactly when rand * 100 > fill_percent * 0xFFFFFFFF.
        dec_lhs = ({7'd0, i_in_data.rand_decide} << 6) + ({7'd0, i_in_data.rand_decide} << 5)
                + ({7'd0, i_in_data.rand_decide} << 2);
        dec_rhs = {r_fill_pct, 32'd0} - {32'd0, r_fill_pct};
        mtu_eff = (r_mtu == '0) ? DEFAULT_MTU : r_mtu;

        n_s1      = '0;
        n_s1.big  = i_in_data.frm_bytes >= mtu_eff;
        n_s1.mode = t_mode'(r_pad_mode);
        n_s1.d    = mtu_eff - i_in_data.frm_bytes;
        var_q     = n_s1.d[15:2];
        n_s1.var_q = var_q;
        div_raw   = (n_s1.mode == MODE_UNIFORM) ? n_s1.d : {1'b0, var_q, 1'b0};
        n_s1.divisor = (div_raw == '0) ? 16'd1 : div_raw;
        n_s1.rnd  = i_in_data.rand_size;
        n_s1.rem  = '0;
        n_s1.tlen = i_in_data.ip_total_len;
        n_s1.csum = i_in_data.ip_checksum;

        if (!r_enable || !i_in_data.headers_present
                || i_in_data.ether_type != ETHERTYPE_IPV4) begin
            n_s1.act = ACT_UNTOUCHED;
        end else if (i_in_data.frm_bytes < r_min_len) begin
            n_s1.act = ACT_SKIPPED;
        end else if (dec_lhs > dec_rhs) begin
            n_s1.act = ACT_NOT_SEL;
        end else begin
            n_s1.act = ACT_PADDED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en_s1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1 <= n_s1;
        end
    end

    // Stages 2 to 9: remainder of the random word, four bits per stage.
    t_work r_dv [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        t_work src;
        t_work n_dv;
        logic  src_v;

        if (g == 0) begin : g_first
            assign src   = r_s1;
            assign src_v = r_v1;
        end else begin : g_rest
            assign src   = r_dv[g-1];
            assign src_v = r_vdv[g-1];
        end

        always_comb begin
            n_dv = src;
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                n_dv.rem = rem_step(n_dv.rem, n_dv.rnd[31], n_dv.divisor);
                n_dv.rnd = n_dv.rnd << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vdv[g] <= 1'b0;
            end else if (en_dv[g]) begin
                r_vdv[g] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en_dv[g]) begin
                r_dv[g] <= n_dv;
            end
        end
    end

    // Stage 10: pad size per mode, then the clamp.
    t_work       w10;
    t_action     n_act10, r_act10;
    logic [10:0] n_pad10, r_pad10;
    logic [15:0] r_tlen10, r_csum10;
    logic [16:0] pad_raw, centred;
    logic [14:0] half_d;

    always_comb begin
        w10     = r_dv[DIV_STAGES-1];
        half_d  = w10.d[15:1];
        if (w10.var_q == '0) begin
            centred = {2'b0, half_d};
        end else begin
            centred = {2'b0, half_d} + {1'b0, w10.rem} - {3'b0, w10.var_q};
        end
        if (centred > {1'b0, w10.d}) begin
            centred = {1'b0, w10.d};
        end

        case (w10.mode)
            MODE_FILL:    pad_raw = {1'b0, w10.d};
            MODE_UNIFORM: pad_raw = {1'b0, w10.rem} + 17'd1;
            MODE_CENTRED: pad_raw = centred;
            default:      pad_raw = '0;
        endcase
        if (w10.big) begin
            pad_raw = '0;
        end

        n_act10 = w10.act;
        n_pad10 = '0;
        if (w10.act == ACT_PADDED) begin
            if (pad_raw == '0) begin
                n_act10 = ACT_ZERO_PAD;
            end else if (pad_raw < {6'd0, PAD_MIN}) begin
                n_pad10 = PAD_MIN;
            end else if (pad_raw > {6'd0, PAD_MAX}) begin
                n_pad10 = PAD_MAX;
            end else begin
                n_pad10 = pad_raw[10:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v10 <= 1'b0;
        end else if (en_s10) begin
            r_v10 <= r_vdv[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s10) begin
            r_act10  <= n_act10;
            r_pad10  <= n_pad10;
            r_tlen10 <= w10.tlen;
            r_csum10 <= w10.csum;
        end
    end

    // Stage 11: new total length and one's complement checksum update.
    t_out_item   n_out, r_out;
    logic [15:0] nlen;
    logic [17:0] csum_sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_comb begin
        nlen     = r_tlen10 + {5'd0, r_pad10};
        csum_sum = {2'b0, ~r_csum10} + {2'b0, ~r_tlen10} + {2'b0, nlen};
        fold1    = {1'b0, csum_sum[15:0]} + {15'd0, csum_sum[17:16]};
        fold2    = fold1[15:0] + {15'd0, fold1[16]};

        n_out.action    = r_act10;
        n_out.pad_bytes = r_pad10;
        if (r_act10 == ACT_PADDED) begin
            n_out.new_ip_total_len = nlen;
            n_out.new_ip_checksum  = ~fold2;
        end else begin
            n_out.new_ip_total_len = r_tlen10;
            n_out.new_ip_checksum  = r_csum10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (en_out) begin
            r_vout <= r_v10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vout;
    assign o_out_data  = r_out;

    `LPD_ASSERT_NOW(a_pad_range, o_out_valid && o_out_data.action == ACT_PADDED,
        o_out_data.pad_bytes >= PAD_MIN && o_out_data.pad_bytes <= PAD_MAX,
        "padded transaction carries a pad outside the allowed range")
    `LPD_ASSERT_NOW(a_pad_zero, o_out_valid && o_out_data.action != ACT_PADDED,
        o_out_data.pad_bytes == '0, "unpadded transaction carries a pad")
    `LPD_ASSERT_NOW(a_full_when_blocked, !o_in_ready,
        o_out_valid && !i_out_ready && r_v1 && r_v10,
        "input blocked while the pipeline still has room")
    `LPD_ASSERT_NEXT(a_stall_keeps, o_out_valid && !i_out_ready, o_out_valid,
        "stalled result left the output register")

endmodule

@@ tb/lpd_checker.sv @@
`timescale 1ns / 100ps

module lpd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  lpd_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  lpd_pkg::t_out_item i_out_data,
    output int                 o_errors,
    output int                 o_pending
);
    import lpd_pkg::*;

    logic        cfg_enable;
    logic [6:0]  cfg_fill;
    logic [15:0] cfg_mtu;
    logic [15:0] cfg_min_len;
    logic [1:0]  cfg_mode;
    t_out_item   decision_q[$];

    function automatic logic [10:0] pick_pad(logic [15:0] cur, logic [15:0] mtu,
                                             logic [1:0] mode, logic [31:0] rnd);
        logic [31:0] d;
        logic [31:0] pad;
        logic [31:0] var_w;
        logic [31:0] off;
        if (cur >= mtu) begin
            return '0;
        end
        d = mtu - cur;
        pad = 0;
        if (mode == MODE_FILL) begin
            pad = d;
        end else if (mode == MODE_UNIFORM) begin
            pad = (rnd % d) + 1;
        end else if (mode == MODE_CENTRED) begin
            var_w = d / 4;
            off = 0;
            if (var_w != 0) begin
                off = (rnd % (var_w * 2)) - var_w;
            end
            pad = ((32'(mtu) + 32'(cur)) / 2) - cur + off;
            if (pad > d) begin
                pad = d;
            end
        end
        if (pad > 0 && pad < PAD_MIN) begin
            pad = PAD_MIN;
        end
        if (pad > PAD_MAX) begin
            pad = PAD_MAX;
        end
        return pad[10:0];
    endfunction

    function automatic t_out_item decide(t_in_item it);
        t_out_item   r;
        logic [63:0] threshold;
        logic [15:0] mtu;
        logic [31:0] s;
        r.action = ACT_UNTOUCHED;
        r.pad_bytes = '0;
        r.new_ip_total_len = it.ip_total_len;
        r.new_ip_checksum = it.ip_checksum;
        threshold = (64'(cfg_fill) * 64'hFFFF_FFFF) / 100;
        if (!cfg_enable || !it.headers_present || it.ether_type != ETHERTYPE_IPV4) begin
            r.action = ACT_UNTOUCHED;
        end else if (it.frm_bytes < cfg_min_len) begin
            r.action = ACT_SKIPPED;
        end else if (64'(it.rand_decide) > threshold) begin
            r.action = ACT_NOT_SEL;
        end else begin
            mtu = (cfg_mtu != 0) ? cfg_mtu : DEFAULT_MTU;
            r.pad_bytes = pick_pad(it.frm_bytes, mtu, cfg_mode, it.rand_size);
            if (r.pad_bytes == 0) begin
                r.action = ACT_ZERO_PAD;
            end else begin
                r.action = ACT_PADDED;
                r.new_ip_total_len = it.ip_total_len + 16'(r.pad_bytes);
                s = {16'd0, ~it.ip_checksum} + {16'd0, ~it.ip_total_len}
                  + {16'd0, r.new_ip_total_len};
                while (s[31:16] != 0) begin
                    s = 32'(s[15:0]) + 32'(s[31:16]);
                end
                r.new_ip_checksum = ~s[15:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        int        bad;
        bad = 0;
        if (!i_rst_n) begin
            cfg_enable <= 1'b0;
            cfg_fill <= '0;
            cfg_mtu <= DEFAULT_MTU;
            cfg_min_len <= '0;
            cfg_mode <= '0;
            o_errors <= 0;
            o_pending <= 0;
            decision_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ENABLE: cfg_enable <= i_cfg_data[0];
                    REG_FILL_PCT: cfg_fill <= i_cfg_data[6:0];
                    REG_MTU: cfg_mtu <= i_cfg_data;
                    REG_MIN_LEN: cfg_min_len <= i_cfg_data;
                    REG_PAD_MODE: cfg_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                decision_q.push_back(decide(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (decision_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %p",
                             $time, i_out_data);
                    bad++;
                end else begin
                    want = decision_q.pop_front();
                    if (want.action != i_out_data.action) begin
                        $display("%0t: action expected %0d actual %0d", $time,
                                 want.action, i_out_data.action);
                        bad++;
                    end
                    if (want.pad_bytes != i_out_data.pad_bytes) begin
                        $display("%0t: pad_bytes expected %0d actual %0d", $time,
                                 want.pad_bytes, i_out_data.pad_bytes);
                        bad++;
                    end
                    if (want.new_ip_total_len != i_out_data.new_ip_total_len) begin
                        $display("%0t: new_ip_total_len expected %h actual %h", $time,
                                 want.new_ip_total_len, i_out_data.new_ip_total_len);
                        bad++;
                    end
                    if (want.new_ip_checksum != i_out_data.new_ip_checksum) begin
                        $display("%0t: new_ip_checksum expected %h actual %h", $time,
                                 want.new_ip_checksum, i_out_data.new_ip_checksum);
                        bad++;
                    end
                end
            end
            o_errors <= o_errors + bad;
            o_pending <= decision_q.size();
        end
    end

endmodule

@@ tb/tb_ipv4_length_padding_decider.sv @@
`timescale 1ns / 100ps

module tb_ipv4_length_padding_decider;
    import lpd_pkg::*;

    localparam int RANDOM_ITEMS = 1130;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_idx;
    logic [15:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_data;
    logic       out_valid;
    logic       out_ready;
    t_out_item  out_data;
    int         errors;
    int         pending;
    int         cycles;
    logic       calm;

    ipv4_length_padding_decider u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_in_data(in_data), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    lpd_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_in_data(in_data), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_data(out_data), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("ipv4_length_padding_decider verification failed");
                $finish;
            end
        end
    end

    // Receiver stalls in bursts; none once the run has calmed down.
    initial begin
        int burst;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end else begin
                burst = $urandom_range(1, 40);
                out_ready <= 1'b1;
                repeat (burst) @(posedge clk);
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(t_in_item it);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    // Mostly eligible IPv4 frames with lengths near the MTU window.
    function automatic t_in_item random_frame();
        t_in_item it;
        it.rand_decide = $urandom;
        it.rand_size = $urandom;
        it.ip_total_len = 16'($urandom);
        it.ip_checksum = 16'($urandom);
        it.headers_present = ($urandom_range(0, 9) != 0);
        it.ether_type = ($urandom_range(0, 7) != 0) ? ETHERTYPE_IPV4 : 16'($urandom);
        case ($urandom_range(0, 3))
            0: it.frm_bytes = 16'($urandom);
            1: it.frm_bytes = 16'($urandom_range(1400, 1520));
            default: it.frm_bytes = 16'($urandom_range(0, 1600));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            it.ip_total_len = 16'($urandom_range(64000, 65535));
        end
        return it;
    endfunction

    task automatic set_phase(logic en, logic [6:0] fill, logic [15:0] mtu,
                             logic [15:0] min_len, logic [1:0] mode);
        in_valid <= 1'b0;
        @(posedge clk);
        wait_idle();
        write_reg(REG_ENABLE, 16'(en));
        write_reg(REG_FILL_PCT, 16'(fill));
        write_reg(REG_MTU, mtu);
        write_reg(REG_MIN_LEN, min_len);
        write_reg(REG_PAD_MODE, 16'(mode));
    endtask

    initial begin
        t_in_item it;
        int       n;
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: enable is off, so everything passes through.
        it = '1;
        send_frame(it);
        it.ether_type = ETHERTYPE_IPV4;
        send_frame(it);

        set_phase(1'b1, 7'd100, 16'd0, 16'd0, MODE_FILL);
        it = '0;
        it.ether_type = ETHERTYPE_IPV4;
        it.headers_present = 1'b1;
        send_frame(it);
        it.frm_bytes = 16'd1459;
        send_frame(it);
        it.frm_bytes = 16'd1460;
        send_frame(it);
        it.frm_bytes = 16'd1000;
        it.ip_total_len = 16'hFFFF;
        it.ip_checksum = 16'hFFFF;
        send_frame(it);
        it.headers_present = 1'b0;
        send_frame(it);
        it.headers_present = 1'b1;
        it.ether_type = 16'h86DD;
        send_frame(it);

        set_phase(1'b1, 7'd127, 16'hFFFF, 16'hFFFF, MODE_UNIFORM);
        it.ether_type = ETHERTYPE_IPV4;
        it.frm_bytes = 16'hFFFE;
        send_frame(it);
        it.frm_bytes = 16'hFFFF;
        it.rand_decide = '1;
        it.rand_size = '1;
        send_frame(it);

        set_phase(1'b1, 7'd0, 16'd1460, 16'd0, MODE_CENTRED);
        it.frm_bytes = 16'd100;
        it.rand_decide = 32'd0;
        send_frame(it);
        it.rand_decide = 32'd1;
        send_frame(it);

        set_phase(1'b1, 7'd100, 16'd1460, 16'd0, MODE_CENTRED);
        it.frm_bytes = 16'd1457;
        send_frame(it);
        it.frm_bytes = 16'd200;
        it.rand_size = 32'd0;
        send_frame(it);
        set_phase(1'b1, 7'd100, 16'd1460, 16'd0, MODE_UNUSED);
        send_frame(it);

        n = 0;
        for (int ph = 0; ph < 10; ph++) begin
            set_phase(1'b1, ph == 0 ? 7'd100 : 7'($urandom_range(0, 127)),
                      ph == 1 ? 16'd0 : 16'($urandom_range(64, 1600)),
                      ph == 2 ? 16'hFFFF : 16'($urandom_range(0, 1500)),
                      2'($urandom_range(0, 3)));
            if (ph == 9) begin
                calm = 1'b1;
            end
            for (int k = 0; k < RANDOM_ITEMS / 10; k++) begin
                send_frame(random_frame());
                n++;
                if (n == 300) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) begin
                        @(posedge clk);
                    end
                end
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        wait_idle();
        if (errors == 0) begin
            $display("ipv4_length_padding_decider verification clean");
        end else begin
            $display("ipv4_length_padding_decider verification failed");
        end
        $finish;
    end

endmodule
